[hw/rtl/sras_pkg.sv]
`timescale 1ns / 1ps

package sras_pkg;

    // Field widths of one request and one result.
    localparam int OPC_W     = 3;
    localparam int IDX_IN_W  = 10;
    localparam int LANE_IN_W = 3;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 48;

    // Datapath widths: residual Q17.16, product Q33.32, rounded product Q33.16.
    localparam int FRAC_W = 16;
    localparam int RES_W  = DATA_W + 1;
    localparam int PROD_W = DATA_W + RES_W;
    localparam int RND_W  = PROD_W - FRAC_W;
    localparam int SUM_W  = RND_W + 1;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);
    localparam logic signed [ACC_W-1:0]  ACC_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  ACC_MIN    = {1'b1, {(ACC_W-1){1'b0}}};

    // Defaults for the top-level parameters.
    localparam int LANES_DEFAULT       = 8;
    localparam int INDEX_DEPTH_DEFAULT = 1024;

    // Opcodes.
    localparam logic [OPC_W-1:0] OP_WR_FACTOR = 3'd0;
    localparam logic [OPC_W-1:0] OP_WR_BIAS   = 3'd1;
    localparam logic [OPC_W-1:0] OP_CLR_ROW   = 3'd2;
    localparam logic [OPC_W-1:0] OP_ACCUM     = 3'd3;
    localparam logic [OPC_W-1:0] OP_READ      = 3'd4;

    // Stage enables from the sequencer to each lane.
    typedef struct packed {
        logic mult_en;
        logic round_en;
    } lane_ctrl_t;

endpackage

[hw/rtl/sras_in_if.sv]
`timescale 1ns / 1ps

interface sras_in_if
    import sras_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OPC_W-1:0]         opcode;
    logic [IDX_IN_W-1:0]      row_index;
    logic [IDX_IN_W-1:0]      col_index;
    logic [LANE_IN_W-1:0]     lane;
    logic signed [DATA_W-1:0] data_value;

    modport source (
        output valid, opcode, row_index, col_index, lane, data_value,
        input  ready
    );

    modport sink (
        input  valid, opcode, row_index, col_index, lane, data_value,
        output ready
    );
endinterface

[hw/rtl/sras_out_if.sv]
`timescale 1ns / 1ps

interface sras_out_if
    import sras_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] acc_value;
    logic                    overflow;

    modport source (
        output valid, acc_value, overflow,
        input  ready
    );

    modport sink (
        input  valid, acc_value, overflow,
        output ready
    );
endinterface

[hw/rtl/sras_ram.sv]
`timescale 1ns / 1ps

module sras_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/sras_lane.sv]
`timescale 1ns / 1ps

module sras_lane
    import sras_pkg::*;
(
    input  logic                     clk,
    input  lane_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] factor,
    input  logic signed [RES_W-1:0]  resid,
    input  logic signed [ACC_W-1:0]  acc,
    output logic signed [ACC_W-1:0]  sum,
    output logic                     sat
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] rnd_full;
    logic signed [RND_W-1:0]  rnd_reg;
    logic signed [RND_W-1:0]  rnd_next;
    logic signed [SUM_W-1:0]  sum_wide;
    logic [SUM_W-ACC_W:0]     sum_top;

    assign prod_next = PROD_W'(factor) * PROD_W'(resid);

    // Round half up: add one half LSB, then drop the fraction bits (floor).
    assign rnd_full = prod_reg + ROUND_HALF;
    assign rnd_next = rnd_full[PROD_W-1:FRAC_W];

    always_ff @(posedge clk)
    begin
        if (ctrl.mult_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.round_en)
        begin
            rnd_reg <= rnd_next;
        end
    end

    assign sum_wide = SUM_W'(acc) + SUM_W'(rnd_reg);
    assign sum_top  = sum_wide[SUM_W-1:ACC_W-1];

    // The sum fits the accumulator only when its sign bit and all bits above it agree.
    always_comb
    begin
        if ((&sum_top) || !(|sum_top))
        begin
            sum = sum_wide[ACC_W-1:0];
            sat = 1'b0;
        end
        else
        begin
            sum = sum_wide[SUM_W-1] ? ACC_MIN : ACC_MAX;
            sat = 1'b1;
        end
    end

endmodule

[hw/rtl/sparse_residual_scatter_accumulate.sv]
`timescale 1ns / 1ps

// Scatter accumulate of one sparse-times-dense factor update in fixed point.
// Requests are taken one at a time by a sequencer that reads, updates and
// writes back a row of per-lane memory banks. A factor, bias or direction-free
// store write and an accumulator row clear pass the execute state and return
// to idle, a read also passes the read-data state, where it waits while the
// previous result still sits in the output register, and an accumulate steps
// through bank read, residual, LANES parallel multiplies, rounding, then the
// saturating add and write-back. After reset the block zeroes the accumulator
// banks one row per cycle and accepts no request until that pass is done;
// direction writes are taken at any time. Row and column indexes are taken
// modulo INDEX_DEPTH, and the overflow flag is sticky until reset.
module sparse_residual_scatter_accumulate
    import sras_pkg::*;
#(
    parameter int LANES       = LANES_DEFAULT,
    parameter int INDEX_DEPTH = INDEX_DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    sras_in_if.sink      item,
    sras_out_if.source   result
);

    localparam int IDX_W  = $clog2(INDEX_DEPTH);
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_RDATA = 3'd3;
    localparam logic [2:0] ST_RESID = 3'd4;
    localparam logic [2:0] ST_MULT  = 3'd5;
    localparam logic [2:0] ST_ROUND = 3'd6;
    localparam logic [2:0] ST_WRITE = 3'd7;

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic [IDX_W-1:0]          clr_cnt_reg;
    logic                      direction_reg;
    logic                      sticky_reg;

    logic [OPC_W-1:0]          op_reg;
    logic [IDX_W-1:0]          row_reg;
    logic [IDX_W-1:0]          col_reg;
    logic [LANE_IN_W-1:0]      lane_reg;
    logic signed [DATA_W-1:0]  data_reg;
    logic [IDX_W-1:0]          row_mod;
    logic [IDX_W-1:0]          col_mod;

    logic signed [RES_W-1:0]   resid_reg;
    logic signed [RES_W-1:0]   resid_next;

    logic                      out_valid_reg;
    logic signed [ACC_W-1:0]   acc_out_reg;
    logic                      ovf_out_reg;

    logic                      accept;
    logic                      exec;
    logic [IDX_W-1:0]          gather;
    logic [IDX_W-1:0]          scatter;
    logic                      lane_ok;
    logic [LANE_W+LANE_IN_W-1:0] lane_wide;
    logic [LANE_W-1:0]         lane_sel;
    logic                      out_load;

    logic                      acc_we;
    logic [IDX_W-1:0]          acc_waddr;
    logic [IDX_W-1:0]          acc_raddr;
    logic                      acc_re;
    logic                      fac_re;

    logic signed [DATA_W-1:0]  bias_rdata;
    logic signed [DATA_W-1:0]  fac_rdata [LANES];
    logic signed [ACC_W-1:0]   acc_rdata [LANES];
    logic signed [ACC_W-1:0]   lane_sum  [LANES];
    logic [LANES-1:0]          lane_sat;
    lane_ctrl_t                lane_ctrl;

    assign accept = item.valid && item.ready;
    assign exec   = (state_reg == ST_EXEC);
    assign item.ready = (state_reg == ST_IDLE);

    // Index reduction modulo the store depth. Below 1024 entries a reciprocal
    // multiply gives the exact quotient of a 10-bit index.
    generate
        if (INDEX_DEPTH >= (1 << IDX_IN_W))
        begin : g_mod_wide
            assign row_mod = IDX_W'(item.row_index);
            assign col_mod = IDX_W'(item.col_index);
        end
        else
        begin : g_mod_recip
            localparam logic [19:0]         RECIP   = 20'(((1 << 20) + INDEX_DEPTH - 1) / INDEX_DEPTH);
            localparam logic [IDX_IN_W-1:0] DEPTH10 = IDX_IN_W'(INDEX_DEPTH);
            logic [29:0]         row_prod;
            logic [29:0]         col_prod;
            logic [19:0]         row_qd;
            logic [19:0]         col_qd;
            logic [IDX_IN_W-1:0] row_rem;
            logic [IDX_IN_W-1:0] col_rem;

            assign row_prod = 30'(item.row_index) * 30'(RECIP);
            assign col_prod = 30'(item.col_index) * 30'(RECIP);
            assign row_qd   = 20'(row_prod[29:20]) * 20'(DEPTH10);
            assign col_qd   = 20'(col_prod[29:20]) * 20'(DEPTH10);
            assign row_rem  = item.row_index - row_qd[IDX_IN_W-1:0];
            assign col_rem  = item.col_index - col_qd[IDX_IN_W-1:0];
            assign row_mod  = row_rem[IDX_W-1:0];
            assign col_mod  = col_rem[IDX_W-1:0];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= item.opcode;
            row_reg  <= row_mod;
            col_reg  <= col_mod;
            lane_reg <= item.lane;
            data_reg <= item.data_value;
        end
        if (state_reg == ST_RESID)
        begin
            resid_reg <= resid_next;
        end
        if (out_load)
        begin
            acc_out_reg <= lane_ok ? acc_rdata[lane_sel] : '0;
            ovf_out_reg <= sticky_reg;
        end
    end

    assign gather  = direction_reg ? col_reg : row_reg;
    assign scatter = direction_reg ? row_reg : col_reg;

    assign lane_ok   = ({{(32-LANE_IN_W){1'b0}}, lane_reg} < 32'(LANES));
    assign lane_wide = {{LANE_W{1'b0}}, lane_reg};
    assign lane_sel  = lane_wide[LANE_W-1:0];

    assign resid_next = RES_W'(data_reg) - RES_W'(bias_rdata);

    // The result register is loaded once it is empty or being drained.
    assign out_load = (state_reg == ST_RDATA) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == IDX_W'(INDEX_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (op_reg)
                    OP_ACCUM: state_next = ST_RESID;
                    OP_READ:  state_next = ST_RDATA;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_RDATA:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESID: state_next = ST_MULT;
            ST_MULT:  state_next = ST_ROUND;
            ST_ROUND: state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            direction_reg <= 1'b0;
            sticky_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (cfg_we)
            begin
                direction_reg <= cfg_wdata;
            end
            if ((state_reg == ST_WRITE) && (|lane_sat))
            begin
                sticky_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.acc_value = acc_out_reg;
    assign result.overflow  = ovf_out_reg;

    // Factor, bias and accumulator bank port control, shared by all lanes.
    assign fac_re = exec && (op_reg == OP_ACCUM);
    assign acc_re = exec && ((op_reg == OP_ACCUM) || (op_reg == OP_READ));
    assign acc_raddr = (op_reg == OP_READ) ? col_reg : scatter;
    assign acc_we = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE)
                    || (exec && (op_reg == OP_CLR_ROW));

    always_comb
    begin
        case (state_reg)
            ST_CLEAR: acc_waddr = clr_cnt_reg;
            ST_WRITE: acc_waddr = scatter;
            default:  acc_waddr = col_reg;
        endcase
    end

    assign lane_ctrl.mult_en  = (state_reg == ST_MULT);
    assign lane_ctrl.round_en = (state_reg == ST_ROUND);

    sras_ram #(
        .WIDTH (DATA_W),
        .DEPTH (INDEX_DEPTH)
    ) u_bias_ram (
        .clk   (clk),
        .we    (exec && (op_reg == OP_WR_BIAS)),
        .waddr (row_reg),
        .wdata (data_reg),
        .re    (fac_re),
        .raddr (row_reg),
        .rdata (bias_rdata)
    );

    generate
        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic fac_we;

            assign fac_we = exec && (op_reg == OP_WR_FACTOR) && lane_ok
                            && (lane_sel == LANE_W'(l));

            sras_ram #(
                .WIDTH (DATA_W),
                .DEPTH (INDEX_DEPTH)
            ) u_factor_ram (
                .clk   (clk),
                .we    (fac_we),
                .waddr (row_reg),
                .wdata (data_reg),
                .re    (fac_re),
                .raddr (gather),
                .rdata (fac_rdata[l])
            );

            sras_ram #(
                .WIDTH (ACC_W),
                .DEPTH (INDEX_DEPTH)
            ) u_acc_ram (
                .clk   (clk),
                .we    (acc_we),
                .waddr (acc_waddr),
                .wdata ((state_reg == ST_WRITE) ? lane_sum[l] : '0),
                .re    (acc_re),
                .raddr (acc_raddr),
                .rdata (acc_rdata[l])
            );

            sras_lane u_lane (
                .clk    (clk),
                .ctrl   (lane_ctrl),
                .factor (fac_rdata[l]),
                .resid  (resid_reg),
                .acc    (acc_rdata[l]),
                .sum    (lane_sum[l]),
                .sat    (lane_sat[l])
            );
        end
    endgenerate

    // A write-back always closes a full residual, multiply, round sequence.
    a_write_after_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> ($past(state_reg, 3) == ST_RESID))
        else $error("accumulator write-back without a complete pipeline pass");

    // A request is only decoded in the cycle after it was accepted.
    a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> $past(accept))
        else $error("request decoded without being accepted");

    // A new result comes only from a completed accumulator read.
    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_RDATA) && ($past(op_reg) == OP_READ))
        else $error("result produced outside a read");

    // The overflow flag is sticky until reset.
    a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(sticky_reg))
        else $error("overflow flag cleared");

endmodule
